// ===== hdl/rmts_pkg.sv =====
// ----------------------------------------------------------------------------
// rmts_pkg
// Shared types, codes and constants of the rate monotonic tick scheduler.
// ----------------------------------------------------------------------------
package rmts_pkg;

	localparam int MAX_TASKS   = 16;
	localparam int IDX_W       = $clog2(MAX_TASKS);
	localparam int DVD_W       = 23;
	localparam int CNT_W       = 5;
	localparam int SHARE_SCALE = 100;
	localparam logic [6:0] SHARE_LIMIT_RESET = 7'd99;
	localparam logic [10:0] TOTAL_MAX = 11'd2047;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_ADMIT  = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OCCUPIED = 2'd1;
	localparam logic [1:0] ST_OVER     = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISP,
		S_DIV,
		S_ADMIT,
		S_SCAN,
		S_UPD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic admit_fin;
		logic remove_fin;
		logic none_fin;
		logic scan_step;
		logic upd_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic [1:0] act;
		logic       div_last;
		logic       tab_last;
		logic       out_busy;
	} stat_t;

endpackage

// ===== hdl/rmts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmts_ctrl
// Sequencer that steps the datapath through one transaction at a time.
// ----------------------------------------------------------------------------
module rmts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  rmts_pkg::stat_t st,
	output rmts_pkg::cmd_t  cmd
);
	import rmts_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				case (st.act)
					ACT_TICK:  state_d = S_SCAN;
					ACT_ADMIT: state_d = S_DIV;
					ACT_REMOVE: begin
						cmd.remove_fin = 1'b1;
						state_d        = S_DONE;
					end
					default: begin
						cmd.none_fin = 1'b1;
						state_d      = S_DONE;
					end
				endcase
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_ADMIT;
				end
			end
			S_ADMIT: begin
				cmd.admit_fin = 1'b1;
				state_d       = S_DONE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.tab_last) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				cmd.upd_step = 1'b1;
				if (st.tab_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!st.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hdl/rmts_dp.sv =====
// ----------------------------------------------------------------------------
// rmts_dp
// Task table, share divider, priority scan and result register.
// ----------------------------------------------------------------------------
module rmts_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  rmts_pkg::cmd_t   cmd,
	output rmts_pkg::stat_t  st,
	input  logic             cfg_we,
	input  logic [6:0]       cfg_wdata,
	input  logic [1:0]       action,
	input  logic [3:0]       slot,
	input  logic [15:0]      budget,
	input  logic [15:0]      period,
	input  logic [15:0]      runnable_mask,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [3:0]       chosen_task,
	output logic             idle,
	output logic [10:0]      total_share
);
	import rmts_pkg::*;

	logic [6:0]       limit_q;
	logic [1:0]       act_q;
	logic [IDX_W-1:0] slot_q;
	logic [15:0]      bud_q, per_q, mask_q;
	logic [DVD_W-1:0] dvd_q;
	logic [16:0]      rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             found_q;
	logic [IDX_W-1:0] best_q;
	logic [15:0]      best_per_q;
	logic [10:0]      total_q;
	logic [1:0]       res_status_q;
	logic [3:0]       res_chosen_q;
	logic             res_idle_q;
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [3:0]       out_chosen_q;
	logic             out_idle_q;
	logic [10:0]      out_total_q;

	logic [MAX_TASKS-1:0] valid_q;
	logic [15:0] tbud_q [MAX_TASKS];
	logic [15:0] tper_q [MAX_TASKS];
	logic [15:0] left_q [MAX_TASKS];
	logic [15:0] cd_q   [MAX_TASKS];
	logic [6:0]  tshare_q [MAX_TASKS];

	logic [IDX_W-1:0] idx;
	logic [16:0]      trial;
	logic             qbit;
	logic             div_last, tab_last;
	logic             eligible;
	logic [11:0]      sum;
	logic [6:0]       rshare;
	logic             admit_ok;

	assign idx      = cnt_q[IDX_W-1:0];
	assign trial    = {rem_q[15:0], dvd_q[DVD_W-1]};
	assign qbit     = (trial >= {1'b0, per_q});
	assign div_last = (cnt_q == CNT_W'(DVD_W - 1));
	assign tab_last = (cnt_q == CNT_W'(MAX_TASKS - 1));
	assign eligible = valid_q[idx] && mask_q[idx] && (left_q[idx] != 16'd0) &&
		(!found_q || (tper_q[idx] < best_per_q));
	assign sum      = {1'b0, total_q} + {5'd0, dvd_q[6:0]};
	assign rshare   = tshare_q[slot_q];
	assign admit_ok = !valid_q[slot_q] && (per_q != 16'd0) &&
		(dvd_q <= {{(DVD_W-7){1'b0}}, limit_q});

	assign st.act      = act_q;
	assign st.div_last = div_last;
	assign st.tab_last = tab_last;
	assign st.out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= SHARE_LIMIT_RESET;
			valid_q     <= '0;
			total_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if ((cmd.div_step && div_last) ||
				((cmd.scan_step || cmd.upd_step) && tab_last)) begin
				cnt_q <= '0;
			end else if (cmd.div_step || cmd.scan_step || cmd.upd_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.admit_fin && admit_ok) begin
				valid_q[slot_q] <= 1'b1;
				total_q <= sum[11] ? TOTAL_MAX : sum[10:0];
			end
			if (cmd.remove_fin && valid_q[slot_q]) begin
				valid_q[slot_q] <= 1'b0;
				total_q <= (total_q >= {4'd0, rshare}) ? total_q - {4'd0, rshare} : 11'd0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= action;
			slot_q  <= slot[IDX_W-1:0];
			bud_q   <= budget;
			per_q   <= period;
			mask_q  <= runnable_mask;
			dvd_q   <= DVD_W'(budget) * DVD_W'(SHARE_SCALE);
			rem_q   <= '0;
			found_q <= 1'b0;
			best_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? trial - {1'b0, per_q} : trial;
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
		end
		if (cmd.admit_fin) begin
			res_chosen_q <= '0;
			res_idle_q   <= 1'b0;
			if (valid_q[slot_q]) begin
				res_status_q <= ST_OCCUPIED;
			end else if (!admit_ok) begin
				res_status_q <= ST_OVER;
			end else begin
				res_status_q     <= ST_OK;
				tbud_q[slot_q]   <= bud_q;
				tper_q[slot_q]   <= per_q;
				left_q[slot_q]   <= bud_q;
				cd_q[slot_q]     <= per_q;
				tshare_q[slot_q] <= dvd_q[6:0];
			end
		end
		if (cmd.remove_fin) begin
			res_status_q <= valid_q[slot_q] ? ST_OK : ST_EMPTY;
			res_chosen_q <= '0;
			res_idle_q   <= 1'b0;
		end
		if (cmd.none_fin) begin
			res_status_q <= ST_OK;
			res_chosen_q <= '0;
			res_idle_q   <= 1'b0;
		end
		if (cmd.scan_step && eligible) begin
			found_q    <= 1'b1;
			best_q     <= idx;
			best_per_q <= tper_q[idx];
		end
		if (cmd.upd_step) begin
			if (valid_q[idx]) begin
				if (cd_q[idx] <= 16'd1) begin
					cd_q[idx]   <= tper_q[idx];
					left_q[idx] <= tbud_q[idx];
				end else begin
					cd_q[idx]   <= cd_q[idx] - 16'd1;
					left_q[idx] <= left_q[idx] - {15'd0, (found_q && best_q == idx)};
				end
			end
			if (tab_last) begin
				res_status_q <= ST_OK;
				res_chosen_q <= found_q ? 4'(best_q) : 4'd0;
				res_idle_q   <= !found_q;
			end
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_chosen_q <= res_chosen_q;
			out_idle_q   <= res_idle_q;
			out_total_q  <= total_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign chosen_task = out_chosen_q;
	assign idle        = out_idle_q;
	assign total_share = out_total_q;

endmodule

// ===== hdl/rate_monotonic_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler
// Periodic task table with admission control and shortest-period grant.
// ----------------------------------------------------------------------------
// A tick makes two 16-entry passes over the task table, one for the grant
// search and one for the countdowns. An admit runs the 23-step restoring
// share divider. One transaction at a time.
// Reset clears the valid bits, the total share and sets the limit to 99.
module rate_monotonic_tick_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [3:0]  slot,
	input  logic [15:0] budget,
	input  logic [15:0] period,
	input  logic [15:0] runnable_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  chosen_task,
	output logic        idle,
	output logic [10:0] total_share
);
	import rmts_pkg::*;

	cmd_t  cmd;
	stat_t st;

	rmts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	rmts_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.action        (action),
		.slot          (slot),
		.budget        (budget),
		.period        (period),
		.runnable_mask (runnable_mask),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.chosen_task   (chosen_task),
		.idle          (idle),
		.total_share   (total_share)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a transaction is in progress");

	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idle |-> chosen_task == 4'd0 && status == ST_OK)
		else $error("idle tick carries a grant or an error status");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

endmodule
